// ----- rtl/iocrb_pkg.sv -----
package iocrb_pkg;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 56;

   localparam logic [1:0] REQ_COMPLETE = 2'd0;
   localparam logic [1:0] REQ_DISPATCH = 2'd1;
   localparam logic [1:0] REQ_RESTART  = 2'd2;

   localparam logic [1:0] KIND_EMIT     = 2'd0;
   localparam logic [1:0] KIND_FINISHED = 2'd1;
   localparam logic [1:0] KIND_REJECT   = 2'd2;
   localparam logic [1:0] KIND_ACK      = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] seq;
      logic [15:0] handle;
      logic [7:0]  gen;
   } result_type;

   typedef struct packed {
      logic push;
      logic flush;
   } stage_ctrl_type;

endpackage

// ----- rtl/in_order_completion_reorder_buffer.sv -----
// Sequence-number reorder buffer. Completions arrive out of order and are held in a window
// of WINDOW slots (handle and empty flag in a one-port synchronous RAM, a valid flag per slot
// in flops) and released in sequence order from the next expected number; empty payloads are
// released silently and completions outside the window come back as rejects. One item is
// processed at a time; the next request is taken only back in idle. A stale completion or an
// unused request stays in idle, a dispatch or restart passes the flush state, a reject the
// check and flush states; a completion visits drain and read once per released slot (one RAM
// read turnaround per slot in the drain loop), then check and flush. Result backpressure can
// hold read, check and flush. Results pass through a one-deep holding stage so that the last
// result of each transaction is marked on tlast. No clearing pass follows reset or restart.
module in_order_completion_reorder_buffer #(
   parameter int WINDOW = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // seq_num, gen_tag, was_encrypted, payload_handle, payload_empty, queue_empty,
   // request_active, start_seq, zero padding
   input  logic [iocrb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                       req_tuser,  // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [iocrb_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_seq, out_handle, out_generation
   output logic [1:0]                       rsp_tuser,  // result_kind
   output logic                             rsp_tlast   // last_of_run
);
   import iocrb_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [31:0]    WIN32 = 32'(WINDOW);
   localparam logic [IDX_W:0] WIN_X = (IDX_W + 1)'(WINDOW);
   localparam logic [IDX_W-1:0] HEAD_MAX = IDX_W'(WINDOW - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DRAIN = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [31:0] seq_num;
   logic [7:0]  gen_tag;
   logic        was_encrypted;
   logic [15:0] payload_handle;
   logic        payload_empty;
   logic        queue_empty;
   logic        request_active;
   logic [31:0] start_seq;

   assign seq_num        = req_tdata[31:0];
   assign gen_tag        = req_tdata[39:32];
   assign was_encrypted  = req_tdata[40];
   assign payload_handle = req_tdata[56:41];
   assign payload_empty  = req_tdata[57];
   assign queue_empty    = req_tdata[58];
   assign request_active = req_tdata[59];
   assign start_seq      = req_tdata[91:60];

   logic [2:0]        state_ff, state_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic [31:0]       next_ff, next_in;
   logic [7:0]        gen_ff, gen_in;
   logic [7:0]        infl_ff, infl_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic              qe_ff, qe_in;
   logic              ra_ff, ra_in;

   logic [16:0]       slot_mem [WINDOW];
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [16:0]       wr_data;
   logic              rd_en;
   logic [16:0]       rd_ff;

   logic [31:0]       seq_gap;
   logic              in_win;
   logic [IDX_W:0]    slot_sum;
   logic [IDX_W:0]    slot_wrap;
   logic [IDX_W-1:0]  slot_idx;
   logic [IDX_W-1:0]  head_next;
   logic              finish;

   stage_ctrl_type    ctrl;
   result_type        push_data;
   logic              push_ready;
   logic              pend_valid;

   assign seq_gap   = seq_num - next_ff;
   assign in_win    = seq_gap < WIN32;
   assign slot_sum  = {1'b0, head_ff} + {1'b0, seq_gap[IDX_W-1:0]};
   assign slot_wrap = slot_sum - WIN_X;
   assign slot_idx  = (slot_sum >= WIN_X) ? slot_wrap[IDX_W-1:0] : slot_sum[IDX_W-1:0];
   assign head_next = (head_ff == HEAD_MAX) ? '0 : head_ff + 1'b1;
   assign finish    = qe_ff && (held_ff == '0) && !ra_ff && (infl_ff == '0);

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      next_in    = next_ff;
      gen_in     = gen_ff;
      infl_in    = infl_ff;
      held_in    = held_ff;
      head_in    = head_ff;
      qe_in      = qe_ff;
      ra_in      = ra_ff;
      wr_en      = 1'b0;
      wr_idx     = slot_idx;
      wr_data    = {payload_empty, payload_handle};
      rd_en      = 1'b0;
      req_tready = 1'b0;
      ctrl       = '0;
      push_data  = '{kind: KIND_ACK, seq: 32'd0, handle: 16'd0, gen: gen_ff};
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_tuser)
                  REQ_DISPATCH: begin
                     if (infl_ff != 8'hFF) begin
                        infl_in = infl_ff + 8'd1;
                     end
                     ctrl.push = 1'b1;
                     state_in  = S_FLUSH;
                  end
                  REQ_RESTART: begin
                     valid_in      = '0;
                     held_in       = '0;
                     infl_in       = '0;
                     gen_in        = gen_ff + 8'd1;
                     next_in       = start_seq;
                     head_in       = '0;
                     push_data.gen = gen_ff + 8'd1;
                     ctrl.push     = 1'b1;
                     state_in      = S_FLUSH;
                  end
                  REQ_COMPLETE: begin
                     if (gen_tag == gen_ff) begin
                        if (was_encrypted && (infl_ff != '0)) begin
                           infl_in = infl_ff - 8'd1;
                        end
                        qe_in = queue_empty;
                        ra_in = request_active;
                        if (!in_win) begin
                           push_data.kind = KIND_REJECT;
                           push_data.seq  = seq_num;
                           ctrl.push      = 1'b1;
                           state_in       = S_CHECK;
                        end else begin
                           wr_en              = 1'b1;
                           valid_in[slot_idx] = 1'b1;
                           if (!valid_ff[slot_idx]) begin
                              held_in = held_ff + 1'b1;
                           end
                           state_in = S_DRAIN;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DRAIN: begin
            if (valid_ff[head_ff]) begin
               rd_en             = 1'b1;
               valid_in[head_ff] = 1'b0;
               if (held_ff != '0) begin
                  held_in = held_ff - 1'b1;
               end
               state_in = S_READ;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_READ: begin
            if (rd_ff[16]) begin
               next_in  = next_ff + 32'd1;
               head_in  = head_next;
               state_in = S_DRAIN;
            end else if (push_ready) begin
               push_data.kind   = KIND_EMIT;
               push_data.seq    = next_ff;
               push_data.handle = rd_ff[15:0];
               ctrl.push        = 1'b1;
               next_in          = next_ff + 32'd1;
               head_in          = head_next;
               state_in         = S_DRAIN;
            end
         end
         S_CHECK: begin
            if (!finish) begin
               state_in = S_FLUSH;
            end else if (push_ready) begin
               push_data.kind = KIND_FINISHED;
               ctrl.push      = 1'b1;
               state_in       = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_valid) begin
               state_in = S_IDLE;
            end else if (push_ready) begin
               ctrl.flush = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         next_ff  <= '0;
         gen_ff   <= '0;
         infl_ff  <= '0;
         held_ff  <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         next_ff  <= next_in;
         gen_ff   <= gen_in;
         infl_ff  <= infl_in;
         held_ff  <= held_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      qe_ff <= qe_in;
      ra_ff <= ra_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= slot_mem[head_ff];
      end
   end

   iocrb_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pend_valid (pend_valid),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/iocrb_rsp_stage.sv -----
module iocrb_rsp_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  iocrb_pkg::stage_ctrl_type        ctrl,
   input  iocrb_pkg::result_type            push_data,
   output logic                             push_ready,
   output logic                             pend_valid,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [iocrb_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_seq, out_handle, out_generation
   output logic [1:0]                       rsp_tuser,  // result_kind
   output logic                             rsp_tlast
);
   import iocrb_pkg::*;

   logic       pend_v_ff, pend_v_in;
   result_type pend_ff, pend_in;
   logic       out_v_ff, out_v_in;
   result_type out_ff, out_in;
   logic       out_last_ff, out_last_in;
   logic       out_free;
   logic       move;

   assign out_free   = !out_v_ff || rsp_tready;
   assign push_ready = !pend_v_ff || out_free;
   assign pend_valid = pend_v_ff;
   // the held result leaves when a newer one arrives or when the run closes
   assign move       = (ctrl.push && pend_v_ff) || ctrl.flush;

   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      out_v_in    = out_v_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      if (move) begin
         out_v_in    = 1'b1;
         out_in      = pend_ff;
         out_last_in = ctrl.flush;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
      if (ctrl.push) begin
         pend_v_in = 1'b1;
         pend_in   = push_data;
      end else if (ctrl.flush) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.gen, out_ff.handle, out_ff.seq};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- rtl/iocrb_checker.sv -----
module iocrb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [iocrb_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]                       req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [iocrb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser,
   input logic                             rsp_tlast
);
   import iocrb_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
      && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_DISPATCH || req_tuser == REQ_RESTART)
      |=> !req_tready)
      else $error("new transaction taken while a command is still in progress");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ACK || rsp_tuser == KIND_FINISHED) |-> rsp_tlast)
      else $error("acknowledge or finished result not marked last");

   a_reject_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_REJECT |-> rsp_tdata[47:32] == 16'd0)
      else $error("reject carries a payload handle");

endmodule

bind in_order_completion_reorder_buffer iocrb_checker u_iocrb_checker (.*);
